FILE: hdl/perceptron_branch_predictor_macros.svh
// Assertion macros shared by the perceptron branch predictor RTL.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define PBP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define PBP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pbp_pkg.sv
// Shared types and constants of the perceptron branch predictor.
package pbp_pkg;

   localparam int PC_W        = 32;
   localparam int THR_W       = 12;
   localparam int SUM_FIELD_W = 13;
   localparam int SUM_FIELD_MAX = 4095;
   localparam int SUM_FIELD_MIN = -4096;
   localparam int GROUP_SIZE  = 8;

   localparam logic [THR_W-1:0] THR_RESET = 12'd44;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GROUP,
      ST_TOTAL,
      ST_UPDATE
   } state_type;

endpackage

FILE: hdl/pbp_intf.sv
// Channel interfaces of the perceptron branch predictor: branch in, result out, threshold.
interface pbp_req_if;
   import pbp_pkg::*;
   logic            valid;
   logic            ready;
   logic [PC_W-1:0] pc;
   logic            outcome;
   modport source (output valid, output pc, output outcome, input ready);
   modport sink   (input valid, input pc, input outcome, output ready);
endinterface

interface pbp_rsp_if;
   import pbp_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          predicted_taken;
   logic signed [SUM_FIELD_W-1:0] perceptron_sum;
   logic                          did_train;
   modport source (output valid, output predicted_taken, output perceptron_sum,
                   output did_train, input ready);
   modport sink   (input valid, input predicted_taken, input perceptron_sum,
                   input did_train, output ready);
endinterface

interface pbp_csr_if;
   import pbp_pkg::*;
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pbp_sum.sv
// Two-level registered adder tree for the perceptron dot product.
module pbp_sum #(
   parameter int HIST_LEN    = 16,
   parameter int WEIGHT_BITS = 8,
   parameter int SUM_W       = 14
) (
   input  logic                                   clock,
   input  logic [(HIST_LEN+1)*WEIGHT_BITS-1:0]    row,
   input  logic [HIST_LEN-1:0]                    hist,
   output logic signed [SUM_W-1:0]                sum
);
   import pbp_pkg::*;

   localparam int TERMS  = HIST_LEN + 1;
   localparam int GROUPS = (TERMS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int TERM_W = WEIGHT_BITS + 1;
   localparam int GRP_W  = WEIGHT_BITS + 4;

   logic [TERMS-1:0]               sign_bits;
   logic signed [TERM_W-1:0]       term [TERMS];
   logic signed [GRP_W-1:0]        grp_in [GROUPS];
   logic signed [GRP_W-1:0]        grp_ff [GROUPS];
   logic signed [SUM_W-1:0]        sum_in;
   logic signed [SUM_W-1:0]        sum_ff;

   // bias weight always counts positive
   assign sign_bits = {1'b1, hist};

   always_comb begin
      logic signed [WEIGHT_BITS-1:0] wv;
      logic signed [TERM_W-1:0]      ext;
      for (int i = 0; i < TERMS; i++) begin
         wv  = row[i*WEIGHT_BITS +: WEIGHT_BITS];
         ext = TERM_W'(wv);
         term[i] = sign_bits[i] ? ext : -ext;
      end
   end

   always_comb begin
      logic signed [GRP_W-1:0] acc;
      int idx;
      for (int g = 0; g < GROUPS; g++) begin
         acc = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            idx = g * GROUP_SIZE + k;
            if (idx < TERMS) begin
               acc = acc + GRP_W'(term[idx]);
            end
         end
         grp_in[g] = acc;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + SUM_W'(grp_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

FILE: hdl/perceptron_branch_predictor.sv
// Top level of the perceptron branch predictor with global history.
//
// One transfer on req carries a resolved branch (pc, outcome). The block reads the weight
// row at pc ^ global history, forms bias + sum of +/-weights, returns the prediction
// (sum >= 0), the sum saturated to 13 bits and whether the row was trained, then trains
// the row and shifts the outcome into the history. From its req transfer a branch passes
// the synchronous weight memory read, which lands at the transfer edge itself, the group and
// total registers of the adder tree, and the train decision and row write-back, which also
// loads the result register. The next branch is taken in the cycle after that, since its row
// index depends on the history this branch leaves, so the block takes no new branch before
// the current one has written back. A waiting result does not block the next req transfer;
// only a second result finding the output register still full holds in the write-back step.
// After reset a clearing pass zeroes the weight memory, one row per cycle, covering all
// 2**INDEX_BITS rows (256 at the default size); req is not ready meanwhile, csr is.
// The threshold is to be written on csr only while the block is idle; it does not enforce this.
`include "perceptron_branch_predictor_macros.svh"

module perceptron_branch_predictor #(
   parameter int HIST_LEN    = 16,
   parameter int INDEX_BITS  = 8,
   parameter int WEIGHT_BITS = 8,
   parameter int WEIGHT_MAX  = 127,
   parameter int WEIGHT_MIN  = -128
) (
   input  logic       clock,
   input  logic       reset,
   pbp_req_if.sink    req_bus,
   pbp_rsp_if.source  rsp_bus,
   pbp_csr_if.sink    csr_bus
);
   import pbp_pkg::*;

   localparam int ROWS   = 1 << INDEX_BITS;
   localparam int TERMS  = HIST_LEN + 1;
   localparam int ROW_W  = TERMS * WEIGHT_BITS;
   localparam int SUM_W  = WEIGHT_BITS + 1 + $clog2(TERMS);
   localparam int CMP_W  = (SUM_W > SUM_FIELD_W) ? SUM_W : SUM_FIELD_W;
   localparam int HX_W   = (HIST_LEN > INDEX_BITS) ? HIST_LEN : INDEX_BITS;

   // effective weight limits: parameter limits narrowed to the weight width
   localparam int FMT_HI = (1 << (WEIGHT_BITS - 1)) - 1;
   localparam int FMT_LO = -(1 << (WEIGHT_BITS - 1));
   localparam int LIM_HI = (WEIGHT_MAX < FMT_HI) ? WEIGHT_MAX : FMT_HI;
   localparam int LIM_LO = (WEIGHT_MIN > FMT_LO) ? WEIGHT_MIN : FMT_LO;
   localparam logic signed [WEIGHT_BITS:0] W_HI = (WEIGHT_BITS+1)'(LIM_HI);
   localparam logic signed [WEIGHT_BITS:0] W_LO = (WEIGHT_BITS+1)'(LIM_LO);

   localparam logic signed [CMP_W-1:0] F_MAX = CMP_W'(SUM_FIELD_MAX);
   localparam logic signed [CMP_W-1:0] F_MIN = CMP_W'(SUM_FIELD_MIN);

   // ---------------------------------------------------------------- state
   state_type                     state_ff, state_in;
   logic [INDEX_BITS-1:0]         clr_idx_ff, clr_idx_in;
   logic [HIST_LEN-1:0]           hist_ff, hist_in;
   logic [THR_W-1:0]              thr_ff, thr_in;
   logic [INDEX_BITS-1:0]         row_idx_ff;
   logic                          outcome_ff;
   logic [ROW_W-1:0]              row_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pred_ff;
   logic signed [SUM_FIELD_W-1:0] sum_field_ff;
   logic                          did_train_ff;

   // weight memory: one row of HIST_LEN history weights plus the bias per entry
   logic [ROW_W-1:0]              wmem [ROWS];

   // ---------------------------------------------------------------- control
   logic                          req_acc;
   logic                          finish;
   logic                          mem_we;
   logic [INDEX_BITS-1:0]         mem_waddr;
   logic [ROW_W-1:0]              mem_wdata;
   logic [INDEX_BITS-1:0]         mem_raddr;
   logic [HX_W-1:0]               hist_x;

   // ---------------------------------------------------------------- datapath
   logic signed [SUM_W-1:0]       sum_w;
   logic                          pred;
   logic [SUM_W-1:0]              mag;
   logic                          train;
   logic signed [CMP_W-1:0]       sum_x;
   logic signed [SUM_FIELD_W-1:0] sum_field;
   logic [ROW_W-1:0]              row_new;
   logic [TERMS-1:0]              sign_bits;

   assign csr_bus.ready = 1'b1;
   assign req_acc       = req_bus.valid && req_bus.ready;

   // row index: low pc bits XOR the packed history (zero-extended when short)
   assign hist_x    = HX_W'(hist_ff);
   assign mem_raddr = req_bus.pc[INDEX_BITS-1:0] ^ hist_x[INDEX_BITS-1:0];

   pbp_sum #(
      .HIST_LEN    (HIST_LEN),
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_W       (SUM_W)
   ) u_sum (
      .clock (clock),
      .row   (row_ff),
      .hist  (hist_ff),
      .sum   (sum_w)
   );

   // train decision on the pre-training sum
   assign pred  = !sum_w[SUM_W-1];
   assign mag   = sum_w[SUM_W-1] ? SUM_W'(-sum_w) : SUM_W'(sum_w);
   assign train = (pred != outcome_ff) || (CMP_W'(mag) <= CMP_W'(thr_ff));

   // result field saturates; only reachable with large parameter choices
   assign sum_x = CMP_W'(sum_w);
   always_comb begin
      if (sum_x > F_MAX) begin
         sum_field = SUM_FIELD_W'(F_MAX);
      end else if (sum_x < F_MIN) begin
         sum_field = SUM_FIELD_W'(F_MIN);
      end else begin
         sum_field = sum_x[SUM_FIELD_W-1:0];
      end
   end

   // trained row: each weight steps toward outcome*history, bias toward outcome
   assign sign_bits = {1'b1, hist_ff};
   always_comb begin
      logic signed [WEIGHT_BITS-1:0] wv;
      logic signed [WEIGHT_BITS:0]   nv;
      for (int i = 0; i < TERMS; i++) begin
         wv = row_ff[i*WEIGHT_BITS +: WEIGHT_BITS];
         if (outcome_ff == sign_bits[i]) begin
            nv = (WEIGHT_BITS+1)'(wv) + (WEIGHT_BITS+1)'(1);
         end else begin
            nv = (WEIGHT_BITS+1)'(wv) - (WEIGHT_BITS+1)'(1);
         end
         if (nv > W_HI) begin
            nv = W_HI;
         end else if (nv < W_LO) begin
            nv = W_LO;
         end
         row_new[i*WEIGHT_BITS +: WEIGHT_BITS] = nv[WEIGHT_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == {INDEX_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_GROUP;
            end
         end
         ST_GROUP:  state_in = ST_TOTAL;
         ST_TOTAL:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- outputs of the FSM
   always_comb begin
      req_bus.ready = 1'b0;
      finish        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = row_idx_ff;
      mem_wdata     = row_new;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_UPDATE: begin
            finish = !rsp_valid_ff || rsp_bus.ready;
            mem_we = finish && train;
         end
         default: begin
         end
      endcase
   end

   assign clr_idx_in   = clr_idx_ff + INDEX_BITS'(1);
   assign hist_in      = finish ? HIST_LEN'({hist_ff, outcome_ff}) : hist_ff;
   assign thr_in       = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : thr_ff;
   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_bus.ready);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         hist_ff      <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         row_idx_ff <= mem_raddr;
         outcome_ff <= req_bus.outcome;
      end
      if (finish) begin
         pred_ff      <= pred;
         sum_field_ff <= sum_field;
         did_train_ff <= train;
      end
   end

   // weight memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wmem[mem_waddr] <= mem_wdata;
      end
      if (req_acc) begin
         row_ff <= wmem[mem_raddr];
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.predicted_taken = pred_ff;
   assign rsp_bus.perceptron_sum  = sum_field_ff;
   assign rsp_bus.did_train       = did_train_ff;

   // ---------------------------------------------------------------- assertions
   `PBP_ASSERT_IMP(a_no_write_on_accept, req_acc, !mem_we, "row write overlaps a new read")
   `PBP_ASSERT_NXT(a_accept_starts_tree, req_acc, state_ff == ST_GROUP, "accept did not start sum")
   `PBP_ASSERT_NXT(a_hist_holds, !finish, $stable(hist_ff), "history moved outside write-back")
   `PBP_ASSERT_NXT(a_miss_trains, finish && pred != outcome_ff, did_train_ff, "untrained miss")

endmodule
